// ===== rtl/core/tpps_pkg.sv =====
package tpps_pkg;

   localparam int DATA_W    = 32;
   localparam int FIELD_W   = 16;
   localparam int DIV_W     = DATA_W + 1;
   localparam int DIV_CNT_W = $clog2(DATA_W);
   localparam int CSR_IDX_W = 8;

   localparam logic [DATA_W-1:0] CLOCK_RESET   = 32'd96000000;
   localparam logic [DATA_W-1:0] MAXRATE_RESET = 32'd500000;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_CLOCK = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE    = 8'd1;

   typedef enum logic [1:0] {
      SEL_TOTAL,
      SEL_ARR,
      SEL_ACH
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOT_GO,
      ST_TOT_WAIT,
      ST_PSC,
      ST_ARR_GO,
      ST_ARR_WAIT,
      ST_MUL,
      ST_ACH_GO,
      ST_ACH_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load_rate;
      logic        div_start;
      div_sel_type sel;
      logic        cap_total;
      logic        cap_psc;
      logic        cap_arr;
      logic        mul_load;
      logic        cap_ach;
      logic        out_load;
   } cmd_type;

endpackage

// ===== rtl/core/timer_prescaler_period_solver.sv =====
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_requested_rate (32)
// rsp      out        rsp_valid / rsp_stall   rsp_prescaler_value (16), rsp_period_value (16),
//                                             rsp_achieved_rate (32)
// csr      in         csr_valid / csr_ready   csr_index (8), csr_data (32)
//
// Each item is solved by three passes through a single shared 32-step restoring
// divider, each with a launch and a capture: the total divider, then a prescaler step,
// the period division, a multiply step, the achieved-rate division and an output step.
// The output step waits while an earlier result is stalled; no item is taken before it ends.
// Synchronous active-high reset returns the controller to idle, drops rsp_valid and
// restores the timer clock to 96 MHz and the rate limit to 500 kHz.
// req_stall is high while an item is being solved. The result sits in an output register,
// so a new item is accepted while an earlier result still waits on rsp_stall.
// csr_ready is always high; users must write registers only while idle; nothing enforces it.
module timer_prescaler_period_solver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tpps_pkg::DATA_W-1:0]    req_requested_rate,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tpps_pkg::FIELD_W-1:0]   rsp_prescaler_value,
   output logic [tpps_pkg::FIELD_W-1:0]   rsp_period_value,
   output logic [tpps_pkg::DATA_W-1:0]    rsp_achieved_rate,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tpps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpps_pkg::DATA_W-1:0]    csr_data
);

   tpps_pkg::cmd_type cmd;
   logic              div_done;
   logic              csr_write;

   // The register file never pushes back.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // The sequencer walks the solve in order: total divider = clock / clamped rate,
   // prescaler = total / 65537 (the smallest value whose period fits in 16 bits),
   // period = total / (prescaler + 1) - 1, then achieved rate = clock divided by the
   // product of both dividers.
   tpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .div_done  (div_done),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the intermediate values, the
   // shared divider and the output register.
   tpps_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .div_done        (div_done),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .requested_rate  (req_requested_rate),
      .prescaler_value (rsp_prescaler_value),
      .period_value    (rsp_period_value),
      .achieved_rate   (rsp_achieved_rate)
   );

endmodule

// ===== rtl/core/tpps_divider.sv =====
module tpps_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tpps_pkg::DATA_W-1:0]  dividend,
   input  logic [tpps_pkg::DIV_W-1:0]   divisor,
   output logic                         done,
   output logic [tpps_pkg::DATA_W-1:0]  quotient
);

   localparam logic [tpps_pkg::DIV_CNT_W-1:0] CNT_LAST =
      tpps_pkg::DIV_CNT_W'(tpps_pkg::DATA_W - 1);

   logic                              running_ff, running_in;
   logic                              done_ff, done_in;
   logic [tpps_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tpps_pkg::DIV_W-1:0]        rem_ff, rem_in;
   logic [tpps_pkg::DATA_W-1:0]       quo_ff, quo_in;
   logic [tpps_pkg::DIV_W-1:0]        divisor_ff, divisor_in;
   logic [tpps_pkg::DIV_W:0]          trial;
   logic [tpps_pkg::DIV_W:0]          diff;
   logic                              fits;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      trial = {rem_ff, quo_ff[tpps_pkg::DATA_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = !diff[tpps_pkg::DIV_W];
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (running_ff) begin
         rem_in = fits ? diff[tpps_pkg::DIV_W-1:0] : trial[tpps_pkg::DIV_W-1:0];
         quo_in = {quo_ff[tpps_pkg::DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> running_ff)
      else $error("divider did not start");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (running_ff && !start && cnt_ff == CNT_LAST) |=> (done_ff && !running_ff))
      else $error("divider did not finish after last step");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !running_ff || $past(start))
      else $error("divider done while still running");

endmodule

// ===== rtl/core/tpps_datapath.sv =====
module tpps_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tpps_pkg::cmd_type              cmd,
   output logic                           div_done,
   input  logic                           csr_write,
   input  logic [tpps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpps_pkg::DATA_W-1:0]    csr_data,
   input  logic [tpps_pkg::DATA_W-1:0]    requested_rate,
   output logic [tpps_pkg::FIELD_W-1:0]   prescaler_value,
   output logic [tpps_pkg::FIELD_W-1:0]   period_value,
   output logic [tpps_pkg::DATA_W-1:0]    achieved_rate
);

   logic [tpps_pkg::DATA_W-1:0]  clk_hz_ff, clk_hz_in;
   logic [tpps_pkg::DATA_W-1:0]  max_rate_ff, max_rate_in;
   logic [tpps_pkg::DATA_W-1:0]  rate_ff, rate_in;
   logic [tpps_pkg::DATA_W-1:0]  total_ff, total_in;
   logic [tpps_pkg::FIELD_W-1:0] psc_ff, psc_in;
   logic [tpps_pkg::FIELD_W-1:0] arr_ff, arr_in;
   logic [tpps_pkg::DIV_W-1:0]   prod_ff, prod_in;
   logic [tpps_pkg::DATA_W-1:0]  ach_ff, ach_in;
   logic [tpps_pkg::FIELD_W-1:0] out_psc_ff, out_psc_in;
   logic [tpps_pkg::FIELD_W-1:0] out_arr_ff, out_arr_in;
   logic [tpps_pkg::DATA_W-1:0]  out_ach_ff, out_ach_in;

   logic [tpps_pkg::DATA_W-1:0]  cap;
   logic [tpps_pkg::DATA_W-1:0]  floor_rate;
   logic [tpps_pkg::FIELD_W-1:0] psc_guess;
   logic [tpps_pkg::FIELD_W-1:0] psc_quot;
   logic [tpps_pkg::FIELD_W:0]   psc_p1;
   logic [tpps_pkg::FIELD_W:0]   arr_p1;
   logic [2*tpps_pkg::FIELD_W+1:0] prod_full;
   logic [tpps_pkg::DATA_W-1:0]  dividend;
   logic [tpps_pkg::DIV_W-1:0]   divisor;
   logic [tpps_pkg::DATA_W-1:0]  quotient;

   tpps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      cap        = (max_rate_ff == '0) ? tpps_pkg::DATA_W'(1) : max_rate_ff;
      floor_rate = (requested_rate == '0) ? tpps_pkg::DATA_W'(1) : requested_rate;
      // Since 65537 is 2^16 + 1, the upper half of the total is either the
      // quotient by 65537 or one above it; the lower half decides which.
      psc_guess  = total_ff[tpps_pkg::DATA_W-1:tpps_pkg::FIELD_W];
      psc_quot   = (total_ff[tpps_pkg::FIELD_W-1:0] >= psc_guess) ?
                   psc_guess : (psc_guess - 1'b1);
      psc_p1     = {1'b0, psc_ff} + 1'b1;
      arr_p1     = {1'b0, arr_ff} + 1'b1;
      prod_full  = {{(tpps_pkg::FIELD_W+1){1'b0}}, psc_p1} *
                   {{(tpps_pkg::FIELD_W+1){1'b0}}, arr_p1};
   end

   always_comb begin
      case (cmd.sel)
         tpps_pkg::SEL_TOTAL: begin
            dividend = clk_hz_ff;
            divisor  = {1'b0, rate_ff};
         end
         tpps_pkg::SEL_ARR: begin
            dividend = total_ff;
            divisor  = {{(tpps_pkg::DIV_W-tpps_pkg::FIELD_W-1){1'b0}}, psc_p1};
         end
         tpps_pkg::SEL_ACH: begin
            dividend = clk_hz_ff;
            divisor  = prod_ff;
         end
         default: begin
            dividend = clk_hz_ff;
            divisor  = {1'b0, rate_ff};
         end
      endcase
   end

   always_comb begin
      clk_hz_in   = clk_hz_ff;
      max_rate_in = max_rate_ff;
      if (csr_write && csr_index == tpps_pkg::CSR_TIMER_CLOCK) begin
         clk_hz_in = csr_data;
      end
      if (csr_write && csr_index == tpps_pkg::CSR_MAX_RATE) begin
         max_rate_in = csr_data;
      end
      rate_in    = cmd.load_rate ? ((floor_rate > cap) ? cap : floor_rate) : rate_ff;
      total_in   = cmd.cap_total ?
                   ((quotient == '0) ? tpps_pkg::DATA_W'(1) : quotient) : total_ff;
      psc_in     = cmd.cap_psc ? psc_quot : psc_ff;
      // The period wraps to 16 bits after the minus one.
      arr_in     = cmd.cap_arr ? (quotient[tpps_pkg::FIELD_W-1:0] - 1'b1) : arr_ff;
      prod_in    = cmd.mul_load ? prod_full[tpps_pkg::DIV_W-1:0] : prod_ff;
      ach_in     = cmd.cap_ach ? quotient : ach_ff;
      out_psc_in = cmd.out_load ? psc_ff : out_psc_ff;
      out_arr_in = cmd.out_load ? arr_ff : out_arr_ff;
      out_ach_in = cmd.out_load ? ach_ff : out_ach_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff   <= tpps_pkg::CLOCK_RESET;
         max_rate_ff <= tpps_pkg::MAXRATE_RESET;
      end else begin
         clk_hz_ff   <= clk_hz_in;
         max_rate_ff <= max_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff    <= rate_in;
      total_ff   <= total_in;
      psc_ff     <= psc_in;
      arr_ff     <= arr_in;
      prod_ff    <= prod_in;
      ach_ff     <= ach_in;
      out_psc_ff <= out_psc_in;
      out_arr_ff <= out_arr_in;
      out_ach_ff <= out_ach_in;
   end

   assign prescaler_value = out_psc_ff;
   assign period_value    = out_arr_ff;
   assign achieved_rate   = out_ach_ff;

   a_rate_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rate |=> rate_ff != '0)
      else $error("clamped rate is zero");

   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.cap_total |=> total_ff != '0)
      else $error("total divider is zero");

   a_prod_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_load |=> (prod_ff != '0 && prod_ff <= 33'h1_0000_0000))
      else $error("divider product out of range");

endmodule

// ===== rtl/core/tpps_ctrl.sv =====
module tpps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              div_done,
   output tpps_pkg::cmd_type cmd
);

   tpps_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpps_pkg::ST_IDLE:     if (req_valid) state_in = tpps_pkg::ST_TOT_GO;
         tpps_pkg::ST_TOT_GO:   state_in = tpps_pkg::ST_TOT_WAIT;
         tpps_pkg::ST_TOT_WAIT: if (div_done) state_in = tpps_pkg::ST_PSC;
         tpps_pkg::ST_PSC:      state_in = tpps_pkg::ST_ARR_GO;
         tpps_pkg::ST_ARR_GO:   state_in = tpps_pkg::ST_ARR_WAIT;
         tpps_pkg::ST_ARR_WAIT: if (div_done) state_in = tpps_pkg::ST_MUL;
         tpps_pkg::ST_MUL:      state_in = tpps_pkg::ST_ACH_GO;
         tpps_pkg::ST_ACH_GO:   state_in = tpps_pkg::ST_ACH_WAIT;
         tpps_pkg::ST_ACH_WAIT: if (div_done) state_in = tpps_pkg::ST_DONE;
         tpps_pkg::ST_DONE:     if (out_free) state_in = tpps_pkg::ST_IDLE;
         default:               state_in = tpps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.sel       = tpps_pkg::SEL_TOTAL;
      req_stall     = (state_ff != tpps_pkg::ST_IDLE);
      case (state_ff)
         tpps_pkg::ST_IDLE:     cmd.load_rate = req_valid;
         tpps_pkg::ST_TOT_GO:   cmd.div_start = 1'b1;
         tpps_pkg::ST_TOT_WAIT: cmd.cap_total = div_done;
         tpps_pkg::ST_PSC:      cmd.cap_psc = 1'b1;
         tpps_pkg::ST_ARR_GO: begin
            cmd.sel       = tpps_pkg::SEL_ARR;
            cmd.div_start = 1'b1;
         end
         tpps_pkg::ST_ARR_WAIT: cmd.cap_arr = div_done;
         tpps_pkg::ST_MUL:      cmd.mul_load = 1'b1;
         tpps_pkg::ST_ACH_GO: begin
            cmd.sel       = tpps_pkg::SEL_ACH;
            cmd.div_start = 1'b1;
         end
         tpps_pkg::ST_ACH_WAIT: cmd.cap_ach = div_done;
         tpps_pkg::ST_DONE:     cmd.out_load = out_free;
         default:               cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == tpps_pkg::ST_TOT_GO)
      else $error("accepted item did not start the solve");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == tpps_pkg::ST_TOT_WAIT || state_ff == tpps_pkg::ST_ARR_WAIT ||
                    state_ff == tpps_pkg::ST_ACH_WAIT))
      else $error("divider finished outside a wait state");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpps_pkg::ST_DONE && rsp_valid_ff && rsp_stall)
         |=> (state_ff == tpps_pkg::ST_DONE && rsp_valid_ff))
      else $error("result overwritten while output was stalled");

endmodule

// ===== tb/timer_prescaler_period_solver_tb.sv =====
module timer_prescaler_period_solver_tb;

   // Largest value that either 16-bit timer divider register can hold.
   localparam logic [31:0] PERIOD_MAX     = 32'h0000_FFFF;
   // Quiet time at the end of the run, after the last result.
   localparam int          SETTLE_CYCLES  = 200;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_ITEMS    = 100;
   // Bound on the slowest correct run: 822 items, each solved with sender gaps and
   // receiver stalls in between.
   localparam int          RUN_LIMIT      = 20_000_000;

   // One expected timer setting, in the order the result ports carry it.
   typedef struct packed {
      logic [15:0] prescaler;
      logic [15:0] period;
      logic [31:0] rate;
   } timer_setting_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_requested_rate;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_prescaler_value;
   logic [15:0] rsp_period_value;
   logic [31:0] rsp_achieved_rate;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   // The testbench's own copy of the two configuration registers.
   logic [31:0] clock_hz_cfg;
   logic [31:0] max_rate_cfg;

   // Timer settings predicted for accepted items, oldest first.
   timer_setting_type pending_settings[$];

   // Percent chance per cycle that the sender holds back or the receiver stalls.
   int idle_pct;
   int stall_pct;

   int error_count;
   int items_sent;
   int results_checked;
   int config_count;

   timer_prescaler_period_solver DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_requested_rate  (req_requested_rate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_prescaler_value (rsp_prescaler_value),
      .rsp_period_value    (rsp_period_value),
      .rsp_achieved_rate   (rsp_achieved_rate),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #10 clock = ~clock;

   // Predicts the timer setting for one requested rate under the current
   // configuration. The rate is clamped to 1..max (a zero max counts as 1),
   // the total divider is clock / rate raised to at least 1, and the smallest
   // prescaler whose period fits in 16 bits is total / 65537. The achieved
   // rate divides the clock by the product of both dividers.
   function automatic timer_setting_type solve_dividers(input logic [31:0] wanted);
      logic [31:0]       ceiling;
      logic [31:0]       rate;
      logic [31:0]       total;
      logic [31:0]       psc;
      logic [31:0]       arr;
      logic [63:0]       product;
      timer_setting_type setting;
      ceiling = (max_rate_cfg == 32'd0) ? 32'd1 : max_rate_cfg;
      rate    = (wanted == 32'd0) ? 32'd1 : wanted;
      if (rate > ceiling) begin
         rate = ceiling;
      end
      total = clock_hz_cfg / rate;
      if (total == 32'd0) begin
         total = 32'd1;
      end
      psc = total / (PERIOD_MAX + 32'd2);
      if (psc > PERIOD_MAX) begin
         psc = PERIOD_MAX;
      end
      arr = (total / (psc + 32'd1) - 32'd1) & PERIOD_MAX;
      product = ({32'd0, psc} + 64'd1) * ({32'd0, arr} + 64'd1);
      setting.prescaler = psc[15:0];
      setting.period    = arr[15:0];
      setting.rate      = 32'({32'd0, clock_hz_cfg} / product);
      return setting;
   endfunction

   // Random receiver back-pressure, changed only at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Every result taken by the receiver is matched against the oldest
   // prediction. Outputs are read at the rising edge, before the block's own
   // updates of that edge land.
   always @(posedge clock) begin
      timer_setting_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_settings.size() == 0) begin
            $error("result with no item outstanding: prescaler %0d period %0d rate %0d",
                   rsp_prescaler_value, rsp_period_value, rsp_achieved_rate);
            error_count++;
         end else begin
            want = pending_settings.pop_front();
            results_checked++;
            if (rsp_prescaler_value !== want.prescaler) begin
               $error("prescaler_value: expected %0d, got %0d",
                      want.prescaler, rsp_prescaler_value);
               error_count++;
            end
            if (rsp_period_value !== want.period) begin
               $error("period_value: expected %0d, got %0d", want.period, rsp_period_value);
               error_count++;
            end
            if (rsp_achieved_rate !== want.rate) begin
               $error("achieved_rate: expected %0d, got %0d", want.rate, rsp_achieved_rate);
               error_count++;
            end
         end
      end
   end

   // Offers one requested rate and returns at the falling edge after it was
   // taken. The valid is left high so that a following item can go out with
   // no bubble; release_req lowers it when the sender has nothing more.
   task automatic send_rate(input logic [31:0] wanted);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_requested_rate <= wanted;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_settings.push_back(solve_dividers(wanted));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   // Stops sending and waits until every predicted result has been taken.
   // Every item yields a result, so the block is idle once this returns.
   task automatic wait_for_results();
      release_req();
      while (pending_settings.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes both registers back to back on the configuration channel. Only
   // called while the block is idle, entered and left at a falling edge.
   task automatic write_config(input logic [31:0] clock_hz, input logic [31:0] max_rate);
      csr_valid <= 1'b1;
      csr_index <= tpps_pkg::CSR_TIMER_CLOCK;
      csr_data  <= clock_hz;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      clock_hz_cfg = clock_hz;
      @(negedge clock);
      csr_index <= tpps_pkg::CSR_MAX_RATE;
      csr_data  <= max_rate;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      max_rate_cfg = max_rate;
      config_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_traffic(input int sender_idle, input int receiver_stall);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
   endtask

   // With the reset configuration of 96 MHz and a 500 kHz limit: zero and minimum rates,
   // a mid rate, the limit with values just below and above it, and the top of the range.
   task automatic test_reset_defaults();
      logic [31:0] rates[8];
      rates = '{32'd0, 32'd1, 32'd2, 32'd1000, 32'd499999, 32'd500000, 32'd500001,
                32'hFFFF_FFFF};
      set_traffic(0, 0);
      foreach (rates[i]) begin
         send_rate(rates[i]);
      end
      wait_for_results();
   endtask

   // A zero rate limit forces every rate to 1. A zero timer clock gives a
   // total divider of 1 after the raise, so both dividers and the rate are 0.
   task automatic test_rate_clamp();
      write_config(32'd96000000, 32'd0);
      send_rate(32'd0);
      send_rate(32'd7);
      send_rate(32'hFFFF_FFFF);
      wait_for_results();
      write_config(32'd0, 32'hFFFF_FFFF);
      send_rate(32'd0);
      send_rate(32'd12345);
      send_rate(32'hFFFF_FFFF);
      wait_for_results();
   endtask

   // The largest clock with rate 1 gives the largest total divider, where
   // the prescaler saturates at 65535. A total of 65536 is the last one with
   // prescaler 0 and a full period; 65537 is the first that needs prescaler 1.
   task automatic test_divider_extremes();
      logic [31:0] rates[6];
      rates = '{32'd1, 32'd2, 32'd65535, 32'd65536, 32'd65537, 32'hFFFF_FFFF};
      set_traffic(0, 0);
      write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      foreach (rates[i]) begin
         send_rate(rates[i]);
      end
      wait_for_results();
      write_config(32'd65537, 32'd500000);
      send_rate(32'd1);
      wait_for_results();
      write_config(32'd65536, 32'd500000);
      send_rate(32'd1);
      wait_for_results();
   endtask

   function automatic logic [31:0] pick_clock();
      case ($urandom_range(0, 5))
         0:       return 32'd96000000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         3:       return $urandom_range(0, 1000);
         default: return $urandom_range(1000000, 200000000);
      endcase
   endfunction

   function automatic logic [31:0] pick_max_rate();
      case ($urandom_range(0, 4))
         0:       return 32'd500000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         3:       return $urandom_range(0, 100);
         default: return $urandom_range(1000, 5000000);
      endcase
   endfunction

   // A fifth of the rates are drawn inside the limit, where the dividers actually vary.
   // Others sit on the clamp edges, are small (up to 2000), are fully random 32-bit
   // values or are aimed at totals near multiples of 65537, where the prescaler
   // steps up.
   function automatic logic [31:0] pick_rate();
      logic [31:0] ceiling;
      logic [63:0] divisor;
      ceiling = (max_rate_cfg == 32'd0) ? 32'd1 : max_rate_cfg;
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return ceiling + $urandom_range(0, 1);
         3: return $urandom();
         4, 5: return $urandom_range(1, ceiling);
         6: return $urandom_range(1, 2000);
         default: begin
            divisor = 64'($urandom_range(0, 65535)) * 64'd65537 + 64'($urandom_range(0, 2));
            if (divisor == 64'd0) begin
               divisor = 64'd1;
            end
            return 32'({32'd0, clock_hz_cfg} / divisor);
         end
      endcase
   endfunction

   // Random traffic in phases. Each phase has its own configuration and its
   // own idling pattern, cycling through no idling, a mostly idle sender, a
   // mostly stalling receiver and light idling on both sides. Half way
   // through each phase the sender holds off until every result is back.
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: set_traffic(0, 0);
            1: set_traffic(71, 0);
            2: set_traffic(0, 71);
            default: set_traffic(9, 9);
         endcase
         if (phase == 0) begin
            write_config(tpps_pkg::CLOCK_RESET, tpps_pkg::MAXRATE_RESET);
         end else if (phase == 1) begin
            write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
         end else begin
            write_config(pick_clock(), pick_max_rate());
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               wait_for_results();
            end
            send_rate(pick_rate());
         end
         wait_for_results();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_requested_rate = '0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      clock_hz_cfg       = tpps_pkg::CLOCK_RESET;
      max_rate_cfg       = tpps_pkg::MAXRATE_RESET;
      idle_pct           = 0;
      stall_pct          = 0;
      error_count        = 0;
      items_sent         = 0;
      results_checked    = 0;
      config_count       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_rate_clamp();
      test_divider_extremes();
      test_random_traffic();

      // Give a stray extra result time to show up before the verdict.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d requested rates under %0d register settings, checked %0d results.",
               items_sent, config_count, results_checked);
      $display("Traffic mixed no idling, a mostly idle sender, a mostly stalled receiver "
               , "and light idling on both sides.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #(RUN_LIMIT);
      $display("Timed out with %0d results still outstanding.", pending_settings.size());
      $display("FAIL");
      $finish;
   end

endmodule
